### rtl/gsope_pkg.sv
// ----------------------------------------------------------------------------
// gsope_pkg: shared definitions for the Gaussian s-orbital point evaluator
// Register indexes, fixed-point constants and the eighth-step exp table.
// ----------------------------------------------------------------------------
package gsope_pkg;

  localparam int MAX_TERMS = 3;
  localparam int TERM_REGS = 3;
  localparam int NUM_LANES = (MAX_TERMS < TERM_REGS) ? MAX_TERMS : TERM_REGS;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_TERM_CNT  = 3'd3,
    REG_TERM_ZERO = 3'd4,
    REG_TERM_ONE  = 3'd5,
    REG_TERM_TWO  = 3'd6,
    REG_THRESHOLD = 3'd7
  } reg_idx_t;

  localparam logic [15:0] LN2_Q16    = 16'd45426;
  localparam logic [20:0] EXP_LIMIT  = 21'd1817040;  // 40 * ln2 in Q.16
  localparam logic [16:0] RECIP_LN2  = 17'd94548;    // floor(2^32 / ln2_q16)
  localparam logic [26:0] RECIP_5    = 27'd107374183; // ceil(2^29 / 5)
  localparam logic [26:0] RECIP_3    = 27'd89478486;  // ceil(2^28 / 3)
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  // e^-(i/8) in Q.30
  function automatic logic [30:0] eighth_step(input logic [2:0] idx);
    logic [30:0] val;
    case (idx)
      3'd0:    val = 31'd1073741824;
      3'd1:    val = 31'd947573834;
      3'd2:    val = 31'd836230973;
      3'd3:    val = 31'd737971244;
      3'd4:    val = 31'd651257337;
      default: val = 31'd574732583;
    endcase
    return val;
  endfunction

endpackage

### rtl/gsope_lane.sv
// ----------------------------------------------------------------------------
// gsope_lane: one basis term
// Scales r^2 by the exponent, reduces by ln2, evaluates exp by table and
// polynomial and weights by the coefficient. Thirteen register stages.
// ----------------------------------------------------------------------------
module gsope_lane
  import gsope_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [49:0] r2,
  input  logic [47:0] term,
  output logic [32:0] mag,
  output logic        neg
);

  logic [23:0] expo;
  logic [23:0] coef;
  logic [23:0] cm;
  assign expo = term[23:0];
  assign coef = term[47:24];
  assign cm   = coef[23] ? (24'd0 - coef) : coef;

  // Stage registers.
  logic [41:0] ph;
  logic [55:0] pl;
  logic [42:0] t;
  logic [20:0] tl6;
  logic [5:0]  k6;
  logic        big6;
  logic [16:0] r7;
  logic [5:0]  k7;
  logic        big7;
  logic [26:0] s_line [6];
  logic [2:0]  idx_line [7];
  logic [5:0]  k_line [8];
  logic        big_line [8];
  logic [30:0] q1;
  logic [26:0] v1;
  logic [26:0] v2;
  logic [25:0] d3;
  logic [26:0] v3;
  logic [26:0] v4;
  logic [30:0] e15;

  // Combinational helpers.
  logic [37:0] rp;
  logic [21:0] r0;
  logic [16:0] r8;
  logic [5:0]  k8;
  logic [53:0] m5;
  logic [57:0] pv1;
  logic [30:0] q2;
  logic [57:0] pv2;
  logic [53:0] m3;
  logic [30:0] q3;
  logic [57:0] pv3;
  logic [30:0] q4;
  logic [57:0] pv4;
  logic [30:0] pq;
  logic [61:0] pe;
  logic [30:0] eshift;
  logic [54:0] pm;

  always_comb begin
    // The quotient estimate is taken from t so that it lands beside tl6.
    rp     = 38'(t[20:0]) * 38'(RECIP_LN2);
    r0     = 22'(tl6) - 22'(22'(k6) * 22'(LN2_Q16));
    if (r7 >= 17'(LN2_Q16)) begin
      r8 = r7 - 17'(LN2_Q16);
      k8 = k7 + 6'd1;
    end else begin
      r8 = r7;
      k8 = k7;
    end
    m5     = 54'(s_line[0]) * 54'(RECIP_5);
    pv1    = 58'(s_line[1]) * 58'(q1);
    q2     = ONE_Q30 - 31'(v1 >> 2);
    pv2    = 58'(s_line[2]) * 58'(q2);
    m3     = 54'(v2) * 54'(RECIP_3);
    q3     = ONE_Q30 - 31'(d3);
    pv3    = 58'(s_line[4]) * 58'(q3);
    q4     = ONE_Q30 - 31'(v3 >> 1);
    pv4    = 58'(s_line[5]) * 58'(q4);
    pq     = ONE_Q30 - 31'(v4);
    pe     = 62'(eighth_step(idx_line[6])) * 62'(pq);
    eshift = big_line[7] ? 31'd0 : (e15 >> k_line[7]);
    pm     = 55'(cm) * 55'(eshift);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph   <= 42'(expo) * 42'(r2[49:32]);
      pl   <= 56'(expo) * 56'(r2[31:0]);
      t    <= 43'(ph) + 43'(pl[55:32]);
      tl6  <= t[20:0];
      big6 <= (t >= 43'(EXP_LIMIT));
      k6   <= rp[37:32];
      r7   <= r0[16:0];
      k7   <= k6;
      big7 <= big6;
      s_line[0]   <= {r8[12:0], 14'd0};
      idx_line[0] <= (r8[15:13] > 3'd5) ? 3'd5 : r8[15:13];
      k_line[0]   <= k8;
      big_line[0] <= big7;
      for (int i = 1; i < 6; i++) s_line[i] <= s_line[i-1];
      for (int i = 1; i < 7; i++) idx_line[i] <= idx_line[i-1];
      for (int i = 1; i < 8; i++) begin
        k_line[i]   <= k_line[i-1];
        big_line[i] <= big_line[i-1];
      end
      q1   <= ONE_Q30 - 31'(m5[53:29]);
      v1   <= pv1[56:30];
      v2   <= pv2[56:30];
      d3   <= m3[53:28];
      v3   <= pv3[56:30];
      v4   <= pv4[56:30];
      e15  <= pe[60:30];
      mag  <= pm[54:22];
      neg  <= coef[23];
    end
  end

endmodule

### rtl/gaussian_s_orbital_point_eval.sv
// ----------------------------------------------------------------------------
// gaussian_s_orbital_point_eval: summed Gaussian s-orbital value at a point
// Streams Q8.16 grid points in and Q4.28 basis values out.
// ----------------------------------------------------------------------------
// One grid point enters per clock cycle while the pipe is not stalled; the
// block is a single 18-stage pipeline (distance and r^2 in three stages,
// thirteen stages per basis term for the scaled exponent, the ln2 reduction
// and the table-plus-polynomial exponential, then a sum stage and the output
// register). All stages advance together: whenever the output register is
// empty or its transaction is taken, s_tready is high and the pipe moves, so
// a stall on the master side holds every stage in place. Each term is
// evaluated in its own lane in parallel, and only the first term_count lanes
// are added. Configuration may only be written while no transaction is in
// flight, since the lanes read the term and centre registers directly.
module gaussian_s_orbital_point_eval
  import gsope_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // point_x[23:0], point_y[47:24], point_z[71:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // point_value[31:0]
  output logic        m_tuser,   // saturated[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [47:0] cfg_wdata
);

  localparam int DEPTH = 18;

  // Configuration registers.
  logic [23:0] center_x;
  logic [23:0] center_y;
  logic [23:0] center_z;
  logic [1:0]  term_count;
  logic [47:0] terms [TERM_REGS];
  logic [31:0] zero_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      center_z       <= '0;
      term_count     <= 2'd1;
      for (int i = 0; i < TERM_REGS; i++) terms[i] <= '0;
      zero_threshold <= 32'd1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_CENTER_X:  center_x       <= cfg_wdata[23:0];
        REG_CENTER_Y:  center_y       <= cfg_wdata[23:0];
        REG_CENTER_Z:  center_z       <= cfg_wdata[23:0];
        REG_TERM_CNT:  term_count     <= cfg_wdata[1:0];
        REG_TERM_ZERO: terms[0]       <= cfg_wdata;
        REG_TERM_ONE:  terms[1]       <= cfg_wdata;
        REG_TERM_TWO:  terms[2]       <= cfg_wdata;
        REG_THRESHOLD: zero_threshold <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data; one shared advance enable.
  logic             en;
  logic [DEPTH-1:0] vld;
  assign en       = !vld[DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // Stage 1: per-axis differences, 25-bit signed.
  logic signed [24:0] dx, dy, dz;
  // Stage 2: squares.
  logic [48:0] sqx, sqy, sqz;
  // Stage 3: r^2 in Q.32.
  logic [49:0] r2;

  logic [24:0] ax, ay, az;
  logic [49:0] px, py, pz;

  always_comb begin
    ax = dx[24] ? 25'(-dx) : 25'(dx);
    ay = dy[24] ? 25'(-dy) : 25'(dy);
    az = dz[24] ? 25'(-dz) : 25'(dz);
    px = 50'(ax) * 50'(ax);
    py = 50'(ay) * 50'(ay);
    pz = 50'(az) * 50'(az);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= $signed({s_tdata[23], s_tdata[23:0]}) - $signed({center_x[23], center_x});
      dy  <= $signed({s_tdata[47], s_tdata[47:24]}) - $signed({center_y[23], center_y});
      dz  <= $signed({s_tdata[71], s_tdata[71:48]}) - $signed({center_z[23], center_z});
      sqx <= px[48:0];
      sqy <= py[48:0];
      sqz <= pz[48:0];
      r2  <= 50'(sqx) + 50'(sqy) + 50'(sqz);
    end
  end

  // Stages 4 to 16: one lane per term.
  logic [32:0] mag [NUM_LANES];
  logic        neg [NUM_LANES];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    gsope_lane u_lane (
      .clk  (clk),
      .en   (en),
      .r2   (r2),
      .term (terms[g]),
      .mag  (mag[g]),
      .neg  (neg[g])
    );
  end

  // Stage 17: signed sum of the active terms.
  logic signed [35:0] sum;
  logic signed [35:0] sum_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (2'(i) < term_count) begin
        if (neg[i]) sum_next = sum_next - $signed(36'(mag[i]));
        else        sum_next = sum_next + $signed(36'(mag[i]));
      end
    end
  end

  // Stage 18: clamp, threshold and output register.
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
      if (sum < 0) begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
      end else if (sum > 36'sh0_FFFF_FFFF) begin
        m_tdata <= '1;
        m_tuser <= 1'b1;
      end else if (sum[31:0] < zero_threshold) begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= sum[31:0];
        m_tuser <= 1'b0;
      end
    end
  end

  // A clamped result always carries the full-scale value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'hFFFF_FFFF)
    else $error("saturated result without full-scale value");

  // An unclamped nonzero result never lies below the threshold.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tdata != 32'd0 |-> m_tdata >= zero_threshold)
    else $error("result below zero threshold was passed");

endmodule
